FILE: rtl/apq_pkg.sv
// Shared constants, codes and types for the array min-first priority queue.
package apq_pkg;

    localparam int DEPTH   = 8;
    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 16;
    localparam int OCC_W   = 4;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_LIST   = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_REMOVED  = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_LISTED   = 3'd4;

    // per-cell update controls
    typedef struct packed {
        logic load;
        logic shift;
    } apq_ctl_t;

    // running minimum handed along the chain
    typedef struct packed {
        logic                       found;
        logic signed [PRIO_W-1:0]   prio;
        logic signed [VALUE_W-1:0]  value;
        logic [IDX_W-1:0]           pos;
    } apq_min_t;

endpackage

FILE: rtl/apq_cell.sv
// One queue slot: holds an entry, folds it into the running minimum, shifts down.
module apq_cell (
    input  logic                               clk,
    input  apq_pkg::apq_ctl_t                  ctl,
    input  logic                               occupied,
    input  logic [apq_pkg::IDX_W-1:0]          idx,
    input  logic signed [apq_pkg::VALUE_W-1:0] new_value,
    input  logic signed [apq_pkg::PRIO_W-1:0]  new_priority,
    input  logic signed [apq_pkg::VALUE_W-1:0] nb_value,
    input  logic signed [apq_pkg::PRIO_W-1:0]  nb_priority,
    input  apq_pkg::apq_min_t                  min_in,
    output apq_pkg::apq_min_t                  min_out,
    output logic signed [apq_pkg::VALUE_W-1:0] value,
    output logic signed [apq_pkg::PRIO_W-1:0]  priority_q
);
    import apq_pkg::*;

    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic signed [PRIO_W-1:0]  prio_reg, prio_next;
    logic                      take;

    always_comb
    begin
        priority if (ctl.shift)
        begin
            value_next = nb_value;
            prio_next  = nb_priority;
        end
        else if (ctl.load)
        begin
            value_next = new_value;
            prio_next  = new_priority;
        end
        else
        begin
            value_next = value_reg;
            prio_next  = prio_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    // strict compare keeps the earlier slot on equal priorities
    assign take = occupied && (!min_in.found || (prio_reg < min_in.prio));

    always_comb
    begin
        if (take)
        begin
            min_out.found = 1'b1;
            min_out.prio  = prio_reg;
            min_out.value = value_reg;
            min_out.pos   = idx;
        end
        else
        begin
            min_out = min_in;
        end
    end

    assign value      = value_reg;
    assign priority_q = prio_reg;

endmodule

FILE: rtl/array_min_priority_queue_unit.sv
// Top level: row of queue cells, command sequencer and output word register.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+------------------------------------------
//  in      | input     | in_valid/in_ready   | action, item_value, item_priority
//  out     | output    | out_valid/out_ready | status, out_value, out_priority, last,
//          |           |                     | occupancy
//
// Insert and remove complete in the edge that takes the command: the minimum ripples
// along the cell row and every occupied cell at or above the winner shifts down in the
// same edge. List first enters the listing state, then sends one word per cycle while
// the output is not stalled, and the input stays blocked until the last word is loaded.
// One command is handled at a time; the next is taken only in a cycle where the output
// register is empty or its word is being taken. A stalled output holds everything. Reset
// clears the count, control and output word only; cells are never read before written.
module array_min_priority_queue_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         action,
    input  logic signed [apq_pkg::VALUE_W-1:0] item_value,
    input  logic signed [apq_pkg::PRIO_W-1:0]  item_priority,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [2:0]                         status,
    output logic signed [apq_pkg::VALUE_W-1:0] out_value,
    output logic signed [apq_pkg::PRIO_W-1:0]  out_priority,
    output logic                               last,
    output logic [apq_pkg::OCC_W-1:0]          occupancy
);
    import apq_pkg::*;

    typedef enum logic {S_IDLE, S_LIST} state_t;

    state_t                    state_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [IDX_W-1:0]          list_idx_reg;
    logic                      out_valid_reg;
    logic [2:0]                status_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [PRIO_W-1:0]  prio_reg;
    logic                      last_reg;
    logic [CNT_W-1:0]          occ_reg;

    apq_ctl_t                  cell_ctl   [DEPTH];
    apq_min_t                  min_chain  [DEPTH+1];
    logic signed [VALUE_W-1:0] cell_value [DEPTH];
    logic signed [PRIO_W-1:0]  cell_prio  [DEPTH];

    logic in_fire, out_free, is_full, is_empty, ins_do, rem_do, list_last;
    logic word_load;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign in_fire   = in_valid && in_ready;
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign ins_do    = in_fire && (action == ACT_INSERT) && !is_full;
    assign rem_do    = in_fire && (action == ACT_REMOVE) && !is_empty;
    assign list_last = (CNT_W'(list_idx_reg) == (count_reg - CNT_W'(1)));

    // a new word enters the output register this edge
    assign word_load = ((state_reg == S_IDLE) && in_fire
                        && (action == ACT_INSERT || action == ACT_REMOVE
                            || (action == ACT_LIST && is_empty)))
                       || ((state_reg == S_LIST) && out_free);

    assign min_chain[0] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] nb_value;
        logic signed [PRIO_W-1:0]  nb_prio;
        logic                      occupied;

        if (i == DEPTH - 1)
        begin : g_end
            // top slot empties on a shift; its contents no longer matter
            assign nb_value = item_value;
            assign nb_prio  = item_priority;
        end
        else
        begin : g_mid
            assign nb_value = cell_value[i+1];
            assign nb_prio  = cell_prio[i+1];
        end

        assign occupied          = (CNT_W'(i) < count_reg);
        assign cell_ctl[i].load  = ins_do && (count_reg == CNT_W'(i));
        assign cell_ctl[i].shift = rem_do && occupied
                                   && (min_chain[DEPTH].pos <= IDX_W'(i));

        apq_cell u_cell (
            .clk          (clk),
            .ctl          (cell_ctl[i]),
            .occupied     (occupied),
            .idx          (IDX_W'(i)),
            .new_value    (item_value),
            .new_priority (item_priority),
            .nb_value     (nb_value),
            .nb_priority  (nb_prio),
            .min_in       (min_chain[i]),
            .min_out      (min_chain[i+1]),
            .value        (cell_value[i]),
            .priority_q   (cell_prio[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            list_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_INSERTED;
            value_reg     <= '0;
            prio_reg      <= '0;
            last_reg      <= 1'b0;
            occ_reg       <= '0;
        end
        else
        begin
            if (word_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        unique case (action)
                            ACT_INSERT:
                            begin
                                value_reg     <= '0;
                                prio_reg      <= '0;
                                last_reg      <= 1'b1;
                                if (is_full)
                                begin
                                    status_reg <= ST_FULL;
                                    occ_reg    <= count_reg;
                                end
                                else
                                begin
                                    status_reg <= ST_INSERTED;
                                    occ_reg    <= count_reg + CNT_W'(1);
                                    count_reg  <= count_reg + CNT_W'(1);
                                end
                            end
                            ACT_REMOVE:
                            begin
                                last_reg      <= 1'b1;
                                if (is_empty)
                                begin
                                    status_reg <= ST_EMPTY;
                                    value_reg  <= '0;
                                    prio_reg   <= '0;
                                    occ_reg    <= count_reg;
                                end
                                else
                                begin
                                    status_reg <= ST_REMOVED;
                                    value_reg  <= min_chain[DEPTH].value;
                                    prio_reg   <= min_chain[DEPTH].prio;
                                    occ_reg    <= count_reg - CNT_W'(1);
                                    count_reg  <= count_reg - CNT_W'(1);
                                end
                            end
                            ACT_LIST:
                            begin
                                if (is_empty)
                                begin
                                    status_reg    <= ST_EMPTY;
                                    value_reg     <= '0;
                                    prio_reg      <= '0;
                                    last_reg      <= 1'b1;
                                    occ_reg       <= count_reg;
                                end
                                else
                                begin
                                    state_reg    <= S_LIST;
                                    list_idx_reg <= '0;
                                end
                            end
                            default:
                            begin
                                // unused code: swallowed, no word
                            end
                        endcase
                    end
                end
                S_LIST:
                begin
                    if (out_free)
                    begin
                        status_reg    <= ST_LISTED;
                        value_reg     <= cell_value[list_idx_reg];
                        prio_reg      <= cell_prio[list_idx_reg];
                        last_reg      <= list_last;
                        occ_reg       <= count_reg;
                        list_idx_reg  <= list_idx_reg + IDX_W'(1);
                        if (list_last)
                            state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_value    = value_reg;
    assign out_priority = prio_reg;
    assign last         = last_reg;
    assign occupancy    = OCC_W'(occ_reg);

endmodule

FILE: rtl/apq_checker.sv
// Port-level checks for the priority queue top level, with its bind.
module apq_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [2:0]                         status,
    input  logic signed [apq_pkg::VALUE_W-1:0] out_value,
    input  logic signed [apq_pkg::PRIO_W-1:0]  out_priority,
    input  logic                               last,
    input  logic [apq_pkg::OCC_W-1:0]          occupancy
);
    import apq_pkg::*;

    // a word waiting for the sink must hold still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_value)
            && $stable(out_priority) && $stable(last) && $stable(occupancy))
        else $error("output word changed while stalled");

    // words that carry no entry carry zeros
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_INSERTED || status == ST_FULL || status == ST_EMPTY)
            |-> out_value == '0 && out_priority == '0)
        else $error("non-entry word with payload");

    // only listing produces more than one word per command
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_LISTED |-> last)
        else $error("single-word result without last");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> occupancy == OCC_W'(DEPTH))
        else $error("full reported below depth");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> occupancy == '0)
        else $error("empty reported with entries stored");

endmodule

bind array_min_priority_queue_unit apq_checker u_apq_checker (.*);
